@@ rtl/i2c_master_transaction_sequencer_defines.svh @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: assertion macros
// Shared property shapes for the checker. Each macro expects clk and rst_n in
// scope.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define I2CMTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define I2CMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after a reset edge.
`define I2CMTS_ASSERT_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

@@ rtl/i2cmts_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer package
// Command, control, ack and outcome codes, engine status codes and the
// packed request and result layouts.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  localparam int SEND_DEPTH_DEF = 16;
  localparam int IN_TDATA_W     = 32;
  localparam int IN_TUSER_W     = 2;
  localparam int OUT_TDATA_W    = 48;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    CTL_CONT      = 2'd0,
    CTL_RSTART    = 2'd1,
    CTL_STOPSTART = 2'd2,
    CTL_STOP      = 2'd3
  } ctl_t;

  typedef enum logic [1:0] {
    ACK_LEAVE  = 2'd0,
    ACK_ASSERT = 2'd1,
    ACK_CLEAR  = 2'd2
  } ack_t;

  typedef enum logic [2:0] {
    OC_BUSY    = 3'd0,
    OC_OK      = 3'd1,
    OC_NODATA  = 3'd2,
    OC_NACK    = 3'd3,
    OC_ARB     = 3'd4,
    OC_BUSERR  = 3'd5,
    OC_UNKNOWN = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    CFG_WRITE_COUNT = 2'd0,
    CFG_READ_COUNT  = 2'd1,
    CFG_TABLE_EN    = 2'd2
  } cfg_idx_t;

  // Engine status codes
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
  localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
  localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  localparam logic [7:0] RX_COUNT_MAX = 8'hFF;

  // Request payload, last field in the lowest bits
  typedef struct packed {
    logic [1:0] pad;
    logic [1:0] entry_control;
    logic [7:0] entry_byte;
    logic [3:0] entry_index;
    logic [7:0] received_byte;
    logic [7:0] status_code;
  } in_data_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [5:0] pad;
    logic [7:0] bytes_received;
    logic [2:0] outcome;
    logic [7:0] receive_position;
    logic [7:0] receive_byte;
    logic       receive_valid;
    logic [7:0] transmit_byte;
    logic       transmit_valid;
    logic [1:0] ack_action;
    logic       clear_start;
    logic       issue_stop;
    logic       issue_start;
  } res_t;

  // Prefetched table reads for the current send position
  typedef struct packed {
    logic [7:0] tx_at_pos;
    logic [1:0] ctl_before_pos;
    logic [7:0] tx_first;
  } tbl_rd_t;

endpackage

@@ rtl/i2cmts_send_table.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: send table
// Outgoing bytes and their control codes, with registered write-first reads
// and a mirror of slot zero.
// ----------------------------------------------------------------------------
module i2cmts_send_table #(
  parameter int DEPTH = i2cmts_pkg::SEND_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_idx,
  input  logic [7:0]                  wr_tx,
  input  logic [1:0]                  wr_ctl,
  input  logic [$clog2(DEPTH)-1:0]    rd_pos,
  input  logic [$clog2(DEPTH)-1:0]    rd_prev,
  output i2cmts_pkg::tbl_rd_t         rd
);

  localparam int IW = $clog2(DEPTH);

  logic [7:0] mem_tx  [DEPTH];
  logic [1:0] mem_ctl [DEPTH];
  logic [7:0] tx_at_pos_r;
  logic [1:0] ctl_before_pos_r;
  logic [7:0] tx_first_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tx[wr_idx]  <= wr_tx;
      mem_ctl[wr_idx] <= wr_ctl;
    end
  end

  // write-first so a load just ahead of a status event is seen
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == rd_pos)) begin
      tx_at_pos_r <= wr_tx;
    end else begin
      tx_at_pos_r <= mem_tx[rd_pos];
    end
    if (wr_en && (wr_idx == rd_prev)) begin
      ctl_before_pos_r <= wr_ctl;
    end else begin
      ctl_before_pos_r <= mem_ctl[rd_prev];
    end
    if (wr_en && (wr_idx == IW'(0))) begin
      tx_first_r <= wr_tx;
    end
  end

  assign rd.tx_at_pos      = tx_at_pos_r;
  assign rd.ctl_before_pos = ctl_before_pos_r;
  assign rd.tx_first       = tx_first_r;

endmodule

@@ rtl/i2c_master_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// Turns byte-engine status codes into engine commands for one transaction.
// ----------------------------------------------------------------------------
// Channels: requests enter on in_* (in_tuser carries the command: load a
// table slot, start a transaction or report a bus status). Every request gives
// exactly one result on out_* carrying the engine flag commands, the byte to
// transmit, any received byte with its index, the outcome code and the
// running receive count.
// The cfg_* port writes write_count, read_count and the table enable; write
// it only while no request is in flight.
// Path: a request passes through the input register, then the result register.
// Throughput: one request per cycle while results are taken; the send table is
// read ahead from the position the previous request leaves, so back-to-back
// status events never wait.
// Reset: sync, active low; clears the send position and receive count,
// sets the outcome to ok and the configuration to zero. Table slots are
// not cleared and must be loaded before use.
// Stall: while out_tready is low the result holds; one more request is taken
// into the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
  parameter int SEND_DEPTH = i2cmts_pkg::SEND_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // status_code[7:0], received_byte[15:8], entry_index[19:16],
  // entry_byte[27:20], entry_control[29:28], zero pad[31:30]
  input  logic [i2cmts_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command[1:0]
  input  logic [i2cmts_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // issue_start[0], issue_stop[1], clear_start[2], ack_action[4:3],
  // transmit_valid[5], transmit_byte[13:6], receive_valid[14],
  // receive_byte[22:15], receive_position[30:23], outcome[33:31],
  // bytes_received[41:34], zero pad[47:42]
  output logic [i2cmts_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_we,
  input  logic [i2cmts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cmts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(SEND_DEPTH);
  localparam int PW = $clog2(SEND_DEPTH + 1);

  // configuration
  logic [4:0] write_count_r;
  logic [7:0] read_count_r;
  logic       table_en_r;

  // input register
  logic                   s1_valid_r;
  logic [1:0]             s1_cmd_r;
  i2cmts_pkg::in_data_t   s1_data_r;

  // result register
  logic                   out_valid_r;
  i2cmts_pkg::res_t       res_r;
  i2cmts_pkg::res_t       res_nxt;

  // transaction state
  logic [PW-1:0]          pos_r;
  logic [PW-1:0]          pos_step;
  logic [PW-1:0]          pos_nxt;
  logic [PW-1:0]          pos_prev;
  logic [7:0]             rx_cnt_r;
  logic [7:0]             rx_cnt_step;
  logic [7:0]             rx_inc;
  i2cmts_pkg::outcome_t   outcome_r;
  i2cmts_pkg::outcome_t   outcome_step;

  // table access
  i2cmts_pkg::tbl_rd_t    tbl_rd;
  logic                   tbl_we;
  logic                   ld_ok;
  logic                   pos_in_tbl;
  logic [7:0]             tx_at_pos;
  i2cmts_pkg::ctl_t       ctl_after;
  i2cmts_pkg::ctl_t       cond;
  logic [PW-1:0]          pos_adv;
  logic                   pos_done;

  logic s1_adv;
  logic in_acc;

  // --------------------------------------------------------------------------
  // Handshake: the input register drains into the result register whenever
  // the result register is empty or being taken.
  // --------------------------------------------------------------------------
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_data_r <= in_tdata;
    end
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_count_r <= '0;
      read_count_r  <= '0;
      table_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (i2cmts_pkg::cfg_idx_t'(cfg_index))
        i2cmts_pkg::CFG_WRITE_COUNT: write_count_r <= cfg_wdata[4:0];
        i2cmts_pkg::CFG_READ_COUNT:  read_count_r  <= cfg_wdata;
        i2cmts_pkg::CFG_TABLE_EN:    table_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Send table. Reads are prefetched from the position that holds after this
  // cycle, so the data matches pos_r when the next request is processed.
  // --------------------------------------------------------------------------
  assign ld_ok    = (9'(s1_data_r.entry_index) < 9'(SEND_DEPTH));
  assign tbl_we   = s1_adv && (s1_cmd_r == i2cmts_pkg::CMD_LOAD) && ld_ok;
  assign pos_nxt  = s1_adv ? pos_step : pos_r;
  assign pos_prev = pos_nxt - PW'(1);

  i2cmts_send_table #(
    .DEPTH (SEND_DEPTH)
  ) u_send_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_idx  (IW'(s1_data_r.entry_index)),
    .wr_tx   (s1_data_r.entry_byte),
    .wr_ctl  (s1_data_r.entry_control),
    .rd_pos  (pos_nxt[IW-1:0]),
    .rd_prev (pos_prev[IW-1:0]),
    .rd      (tbl_rd)
  );

  // Past the table the byte reads as zero; position saturates there.
  assign pos_in_tbl = (pos_r < PW'(SEND_DEPTH));
  assign tx_at_pos  = pos_in_tbl ? tbl_rd.tx_at_pos : 8'h00;
  assign pos_adv    = pos_in_tbl ? (pos_r + PW'(1)) : pos_r;
  assign ctl_after  = (!table_en_r || (pos_r == '0)) ? i2cmts_pkg::CTL_CONT
                                                     : i2cmts_pkg::ctl_t'(tbl_rd.ctl_before_pos);
  assign pos_done   = (9'(pos_r) >= 9'(write_count_r));
  assign rx_inc     = (rx_cnt_r < i2cmts_pkg::RX_COUNT_MAX) ? (rx_cnt_r + 8'd1) : rx_cnt_r;

  // --------------------------------------------------------------------------
  // Request decode: commands for the engine and the next transaction state
  // --------------------------------------------------------------------------
  always_comb begin
    res_nxt      = '0;
    pos_step     = pos_r;
    rx_cnt_step  = rx_cnt_r;
    outcome_step = outcome_r;
    cond         = i2cmts_pkg::CTL_CONT;

    case (i2cmts_pkg::cmd_t'(s1_cmd_r))
      i2cmts_pkg::CMD_LOAD: ;
      i2cmts_pkg::CMD_START: begin
        // ignored while a transaction is running
        if (outcome_r != i2cmts_pkg::OC_BUSY) begin
          rx_cnt_step         = '0;
          outcome_step        = i2cmts_pkg::OC_BUSY;
          res_nxt.issue_start = 1'b1;
        end
      end
      i2cmts_pkg::CMD_STATUS: begin
        case (s1_data_r.status_code)
          i2cmts_pkg::ST_BUS_ERROR: begin
            res_nxt.ack_action = i2cmts_pkg::ACK_ASSERT;
            res_nxt.issue_stop = 1'b1;
            outcome_step       = i2cmts_pkg::OC_BUSERR;
          end
          i2cmts_pkg::ST_START: begin
            res_nxt.clear_start = 1'b1;
            if (write_count_r != '0) begin
              res_nxt.transmit_valid = 1'b1;
              res_nxt.transmit_byte  = tbl_rd.tx_first;
              pos_step               = PW'(1);
            end else begin
              pos_step           = '0;
              res_nxt.issue_stop = 1'b1;
              outcome_step       = i2cmts_pkg::OC_NODATA;
            end
          end
          i2cmts_pkg::ST_RSTART: begin
            rx_cnt_step            = '0;
            res_nxt.transmit_valid = 1'b1;
            res_nxt.transmit_byte  = tx_at_pos;
            pos_step               = pos_adv;
            res_nxt.clear_start    = 1'b1;
          end
          i2cmts_pkg::ST_ARB_LOST: begin
            outcome_step = i2cmts_pkg::OC_ARB;
          end
          i2cmts_pkg::ST_ADDR_W_ACK, i2cmts_pkg::ST_DATA_W_ACK: begin
            if ((s1_data_r.status_code == i2cmts_pkg::ST_ADDR_W_ACK) &&
                (write_count_r == 5'd1)) begin
              res_nxt.issue_stop = 1'b1;
              outcome_step       = i2cmts_pkg::OC_NODATA;
            end else if ((s1_data_r.status_code == i2cmts_pkg::ST_DATA_W_ACK) && pos_done) begin
              // write phase over: restart for the read phase or finish
              if (read_count_r != '0) begin
                res_nxt.issue_start = 1'b1;
              end else begin
                res_nxt.issue_stop = 1'b1;
                outcome_step       = i2cmts_pkg::OC_OK;
              end
            end else begin
              if ((s1_data_r.status_code == i2cmts_pkg::ST_DATA_W_ACK) && (pos_r == '0)) begin
                cond = i2cmts_pkg::CTL_RSTART;
              end else begin
                cond = ctl_after;
              end
              case (cond)
                i2cmts_pkg::CTL_CONT: begin
                  res_nxt.transmit_valid = 1'b1;
                  res_nxt.transmit_byte  = tx_at_pos;
                  pos_step               = pos_adv;
                end
                i2cmts_pkg::CTL_RSTART: begin
                  res_nxt.issue_start = 1'b1;
                end
                i2cmts_pkg::CTL_STOPSTART: begin
                  res_nxt.issue_stop  = 1'b1;
                  res_nxt.issue_start = 1'b1;
                end
                default: begin
                  res_nxt.issue_stop = 1'b1;
                  outcome_step = (s1_data_r.status_code == i2cmts_pkg::ST_ADDR_W_ACK)
                               ? i2cmts_pkg::OC_NODATA : i2cmts_pkg::OC_OK;
                end
              endcase
            end
          end
          i2cmts_pkg::ST_ADDR_W_NACK, i2cmts_pkg::ST_DATA_W_NACK,
          i2cmts_pkg::ST_ADDR_R_NACK: begin
            res_nxt.issue_stop = 1'b1;
            outcome_step       = i2cmts_pkg::OC_NACK;
          end
          i2cmts_pkg::ST_ADDR_R_ACK: begin
            // ack the next byte unless it is the last one wanted
            res_nxt.ack_action = ((9'(rx_cnt_r) + 9'd1) < 9'(read_count_r))
                               ? i2cmts_pkg::ACK_ASSERT : i2cmts_pkg::ACK_CLEAR;
          end
          i2cmts_pkg::ST_DATA_R_ACK, i2cmts_pkg::ST_DATA_R_NACK: begin
            res_nxt.receive_valid    = 1'b1;
            res_nxt.receive_byte     = s1_data_r.received_byte;
            res_nxt.receive_position = rx_cnt_r;
            rx_cnt_step              = rx_inc;
            if (s1_data_r.status_code == i2cmts_pkg::ST_DATA_R_ACK) begin
              res_nxt.ack_action = ((9'(rx_inc) + 9'd1) < 9'(read_count_r))
                                 ? i2cmts_pkg::ACK_ASSERT : i2cmts_pkg::ACK_CLEAR;
            end else begin
              res_nxt.issue_stop = 1'b1;
              outcome_step       = i2cmts_pkg::OC_OK;
            end
          end
          default: begin
            outcome_step = i2cmts_pkg::OC_UNKNOWN;
          end
        endcase
      end
      default: ;
    endcase

    res_nxt.outcome        = outcome_step;
    res_nxt.bytes_received = rx_cnt_step;
  end

  // --------------------------------------------------------------------------
  // Transaction state: advance only as a request moves to the result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rx_cnt_r  <= '0;
      outcome_r <= i2cmts_pkg::OC_OK;
    end else if (s1_adv) begin
      pos_r     <= pos_step;
      rx_cnt_r  <= rx_cnt_step;
      outcome_r <= outcome_step;
    end
  end

endmodule

@@ rtl/i2cmts_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: port checker
// Watches the result channel for holding, reset and field consistency.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cmts_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [i2cmts_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  i2cmts_pkg::res_t view;

  assign view = out_tdata;

  `I2CMTS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  `I2CMTS_ASSERT_RESET(a_out_reset, !out_tvalid, "result valid right after reset")

  `I2CMTS_ASSERT_NOW(a_tx_rx_excl, out_tvalid, !(view.transmit_valid && view.receive_valid), "transmit and receive in one result")

  `I2CMTS_ASSERT_NOW(a_rx_count, out_tvalid && view.receive_valid, (view.bytes_received == view.receive_position + 8'd1) || ((view.receive_position == 8'hFF) && (view.bytes_received == 8'hFF)), "receive count does not follow position")

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_i2cmts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/i2cmts_sequencer_checker.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer: result checker
// Watches the request, result and register-write channels. For each request
// it predicts the engine commands and queues them; each result is compared
// field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module i2cmts_sequencer_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [i2cmts_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [i2cmts_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [i2cmts_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [i2cmts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                 mismatches,
  output int                                 commands_due,
  output int                                 results_checked
);
  import i2cmts_pkg::*;

  localparam int SEND_DEPTH  = SEND_DEPTH_DEF;
  localparam int MAX_PRINTED = 30;

  // Shadow of the sequencer state
  logic [7:0]  tbl_byte [SEND_DEPTH];
  ctl_t        tbl_ctl  [SEND_DEPTH];
  int unsigned send_pos;
  int unsigned rx_cnt;
  outcome_t    oc;
  int unsigned wr_count;
  int unsigned rd_count;
  bit          tbl_en;

  res_t pending_commands[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    // keep the log short when the block is badly broken
    if (mismatches <= MAX_PRINTED)
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               results_checked, what, got, want);
  endtask

  // Hand the byte at the send position to the engine and advance.
  function automatic void send_next(inout res_t r);
    r.transmit_valid = 1'b1;
    r.transmit_byte  = (send_pos < SEND_DEPTH) ? tbl_byte[send_pos] : 8'h00;
    if (send_pos < SEND_DEPTH) send_pos++;
  endfunction

  function automatic res_t next_engine_commands(input logic [1:0] cmd,
                                                input in_data_t   req);
    res_t r;
    ctl_t follow;
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        tbl_byte[req.entry_index] = req.entry_byte;
        tbl_ctl[req.entry_index]  = ctl_t'(req.entry_control);
      end
      CMD_START: begin
        if (oc != OC_BUSY) begin
          rx_cnt        = 0;
          oc            = OC_BUSY;
          r.issue_start = 1'b1;
        end
      end
      CMD_STATUS: begin
        case (req.status_code)
          ST_BUS_ERROR: begin
            r.ack_action = ACK_ASSERT;
            r.issue_stop = 1'b1;
            oc           = OC_BUSERR;
          end
          ST_START: begin
            send_pos      = 0;
            r.clear_start = 1'b1;
            if (wr_count != 0) send_next(r);
            else begin
              r.issue_stop = 1'b1;
              oc           = OC_NODATA;
            end
          end
          ST_RSTART: begin
            rx_cnt        = 0;
            r.clear_start = 1'b1;
            send_next(r);
          end
          ST_ARB_LOST: oc = OC_ARB;
          ST_ADDR_W_ACK, ST_DATA_W_ACK: begin
            if (req.status_code == ST_ADDR_W_ACK && wr_count == 1) begin
              r.issue_stop = 1'b1;
              oc           = OC_NODATA;
            end else if (req.status_code == ST_DATA_W_ACK && send_pos >= wr_count) begin
              // write phase done: turn around for reading or finish
              if (rd_count != 0) r.issue_start = 1'b1;
              else begin
                r.issue_stop = 1'b1;
                oc           = OC_OK;
              end
            end else begin
              if (req.status_code == ST_DATA_W_ACK && send_pos == 0) follow = CTL_RSTART;
              else if (!tbl_en || send_pos == 0)                        follow = CTL_CONT;
              else                                                      follow = tbl_ctl[send_pos - 1];
              case (follow)
                CTL_CONT:   send_next(r);
                CTL_RSTART: r.issue_start = 1'b1;
                CTL_STOPSTART: begin
                  r.issue_stop  = 1'b1;
                  r.issue_start = 1'b1;
                end
                default: begin
                  r.issue_stop = 1'b1;
                  oc = (req.status_code == ST_ADDR_W_ACK) ? OC_NODATA : OC_OK;
                end
              endcase
            end
          end
          ST_ADDR_W_NACK, ST_DATA_W_NACK, ST_ADDR_R_NACK: begin
            r.issue_stop = 1'b1;
            oc           = OC_NACK;
          end
          ST_ADDR_R_ACK: r.ack_action = (rx_cnt + 1 < rd_count) ? ACK_ASSERT : ACK_CLEAR;
          ST_DATA_R_ACK, ST_DATA_R_NACK: begin
            r.receive_valid    = 1'b1;
            r.receive_byte     = req.received_byte;
            r.receive_position = rx_cnt[7:0];
            if (rx_cnt < RX_COUNT_MAX) rx_cnt++;
            if (req.status_code == ST_DATA_R_ACK)
              r.ack_action = (rx_cnt + 1 < rd_count) ? ACK_ASSERT : ACK_CLEAR;
            else begin
              r.issue_stop = 1'b1;
              oc           = OC_OK;
            end
          end
          default: oc = OC_UNKNOWN;
        endcase
      end
      default: ;
    endcase
    r.outcome        = oc;
    r.bytes_received = rx_cnt[7:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (!rst_n) begin
      send_pos = 0;
      rx_cnt   = 0;
      oc       = OC_OK;
      wr_count = 0;
      rd_count = 0;
      tbl_en   = 1'b0;
      pending_commands.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRITE_COUNT: wr_count = cfg_wdata[4:0];
          CFG_READ_COUNT:  rd_count = cfg_wdata;
          CFG_TABLE_EN:    tbl_en   = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_commands.push_back(next_engine_commands(in_tuser, in_data_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata);
        if (pending_commands.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], 0);
        end else begin
          want = pending_commands.pop_front();
          if (got.issue_start !== want.issue_start)
            report_mismatch("issue_start", got.issue_start, want.issue_start);
          if (got.issue_stop !== want.issue_stop)
            report_mismatch("issue_stop", got.issue_stop, want.issue_stop);
          if (got.clear_start !== want.clear_start)
            report_mismatch("clear_start", got.clear_start, want.clear_start);
          if (got.ack_action !== want.ack_action)
            report_mismatch("ack_action", got.ack_action, want.ack_action);
          if (got.transmit_valid !== want.transmit_valid)
            report_mismatch("transmit_valid", got.transmit_valid, want.transmit_valid);
          if (got.transmit_byte !== want.transmit_byte)
            report_mismatch("transmit_byte", got.transmit_byte, want.transmit_byte);
          if (got.receive_valid !== want.receive_valid)
            report_mismatch("receive_valid", got.receive_valid, want.receive_valid);
          if (got.receive_byte !== want.receive_byte)
            report_mismatch("receive_byte", got.receive_byte, want.receive_byte);
          if (got.receive_position !== want.receive_position)
            report_mismatch("receive_position", got.receive_position, want.receive_position);
          if (got.outcome !== want.outcome)
            report_mismatch("outcome", got.outcome, want.outcome);
          if (got.bytes_received !== want.bytes_received)
            report_mismatch("bytes_received", got.bytes_received, want.bytes_received);
        end
        results_checked++;
      end
    end
    commands_due = pending_commands.size();
  end

endmodule

@@ tb/tb_i2c_master_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer testbench
// Loads the send table, runs a short directed pass over every command and
// status code, then streams randomized transfers under changing register
// settings with random gaps and stalls on both channels. A separate checker
// predicts and compares every result; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_sequencer;
  import i2cmts_pkg::*;

  localparam int ITEMS_TARGET  = 1650;
  localparam int MAX_GAP       = 8;
  localparam int LONG_HOLD     = 48;   // receiver hold-off, long enough to back up the input
  localparam int SETTLE_CYCLES = 4;    // covers the two stages plus margin
  localparam int TAIL_CYCLES   = 8;
  // Longest correct quiet stretch is the long hold plus a gap and the latency;
  // take a wide margin over that.
  localparam int QUIET_LIMIT   = 2000;

  // command code with no function: the block must answer it with a result that carries no engine command
  localparam logic [IN_TUSER_W-1:0] CMD_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int mismatches;
  int commands_due;
  int results_checked;

  int requests_sent = 0;
  int transfers     = 0;
  int settings      = 0;
  int quiet_cycles  = 0;
  bit steady        = 1'b0;   // when set, both sides stream without gaps

  int unsigned cur_wr;
  int unsigned cur_rd;
  bit          cur_en;

  i2c_master_transaction_sequencer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  i2cmts_sequencer_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .commands_due    (commands_due),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: draw a stall per result; twice, while requests are still in
  // flight, hold off for a long stretch so the block fills and stalls its input.
  initial begin : result_sink
    int hold;
    int taken;
    int holds_done;
    taken      = 0;
    holds_done = 0;
    forever begin
      if (holds_done < 2 && taken >= 500 * (holds_done + 1) && commands_due >= 2) begin
        hold = LONG_HOLD;
        holds_done++;
      end else begin
        hold = steady ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      taken++;
    end
  end

  // Random content for every field but the zeroed pad; the relevant ones get overwritten.
  function automatic in_data_t random_fields();
    in_data_t d;
    d     = in_data_t'($urandom);
    d.pad = '0;
    return d;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  // Called on a clock edge; returns on the accepting edge with valid still high.
  task automatic send_request(input logic [IN_TUSER_W-1:0] cmd, input in_data_t req);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= req;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    requests_sent++;
  endtask

  task automatic send_load(input int idx, input logic [7:0] b, input ctl_t ctl);
    in_data_t d;
    d               = random_fields();
    d.entry_index   = idx[3:0];
    d.entry_byte    = b;
    d.entry_control = ctl;
    send_request(CMD_LOAD, d);
  endtask

  task automatic send_status(input logic [7:0] code);
    in_data_t d;
    d             = random_fields();
    d.status_code = code;
    send_request(CMD_STATUS, d);
  endtask

  // Stray request: any command, and a status that is either a listed code
  // (multiples of eight up to 0x58) or any byte at all.
  task automatic send_noise();
    in_data_t d;
    d = random_fields();
    if ($urandom_range(0, 1) == 0) d.status_code = 8'($urandom_range(0, 11)) << 3;
    send_request(2'($urandom_range(0, 3)), d);
  endtask

  // Step of a transfer; now and then replace it with a stray request.
  task automatic status_or_noise(input logic [7:0] code);
    if ($urandom_range(0, 11) == 0) send_noise();
    else                           send_status(code);
  endtask

  // Drop valid, wait for every result to come back, then let the pipe settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (commands_due == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back; only call while idle.
  task automatic program_regs(input int unsigned wr, input int unsigned rd, input bit en);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WRITE_COUNT;
    cfg_wdata <= 8'(wr);
    @(posedge clk);
    cfg_index <= CFG_READ_COUNT;
    cfg_wdata <= 8'(rd);
    @(posedge clk);
    cfg_index <= CFG_TABLE_EN;
    cfg_wdata <= 8'(en);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // One well-formed transfer for the current settings: start, address and
  // data writes, then the read turnaround and the received bytes.
  task automatic run_transfer();
    int extra;
    send_request(CMD_START, random_fields());
    status_or_noise(ST_START);
    if (cur_wr != 0) begin
      status_or_noise(ST_ADDR_W_ACK);
      repeat (cur_wr - 1 + $urandom_range(0, 1)) status_or_noise(ST_DATA_W_ACK);
    end
    if (cur_rd != 0) begin
      // long reads run three bytes past the limit to saturate the count
      extra = (cur_rd > 200) ? 3 : 0;
      status_or_noise(ST_RSTART);
      status_or_noise(ST_ADDR_R_ACK);
      repeat (cur_rd - 1 + extra) status_or_noise(ST_DATA_R_ACK);
      status_or_noise(ST_DATA_R_NACK);
    end
    transfers++;
  endtask

  initial begin : stimulus
    int phase;
    int n_xfer;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_regs(3, 2, 1'b1);

    // Fill every table slot first so no read ever hits an unwritten entry.
    // Bytes run from 0x00 to 0xFF, controls cycle through all four codes.
    for (int i = 0; i < SEND_DEPTH_DEF; i++)
      send_load(i, 8'(i * 17), ctl_t'(i % 4));

    // Directed pass: one short transfer through the table controls, then the
    // error and odd cases.
    send_request(CMD_UNUSED, random_fields());
    send_request(CMD_START, random_fields());
    send_request(CMD_START, random_fields());   // ignored while busy
    send_status(ST_START);
    send_status(ST_ADDR_W_ACK);                 // slot 0 says continue
    send_status(ST_DATA_W_ACK);                 // slot 1 asks for a repeated start
    send_status(ST_RSTART);
    send_status(ST_DATA_W_ACK);                 // write phase over, turn to read
    send_status(ST_ADDR_R_ACK);
    begin : rx_extremes
      in_data_t d;
      d               = random_fields();
      d.status_code   = ST_DATA_R_ACK;
      d.received_byte = 8'hFF;
      send_request(CMD_STATUS, d);
      d.status_code   = ST_DATA_R_NACK;
      d.received_byte = 8'h00;
      send_request(CMD_STATUS, d);
    end
    send_status(8'hFF);                         // unlisted status
    send_status(ST_BUS_ERROR);
    send_status(ST_ARB_LOST);
    send_status(ST_ADDR_W_NACK);
    send_status(ST_DATA_W_NACK);
    send_status(ST_ADDR_R_NACK);

    // Random part: each phase picks new settings while idle, then streams
    // transfers mixed with table reloads and stray requests.
    phase = 0;
    while (requests_sent < ITEMS_TARGET) begin
      drain();
      case (phase)
        0: begin cur_wr = 16; cur_rd = 255; cur_en = 1'b0; end
        1: begin cur_wr = 0;  cur_rd = 0;   cur_en = 1'b1; end
        2: begin cur_wr = 1;  cur_rd = 1;   cur_en = 1'b1; end
        3: begin cur_wr = 16; cur_rd = 0;   cur_en = 1'b1; end
        default: begin
          cur_wr = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(0, 5);
          cur_rd = $urandom_range(0, 6);
          cur_en = $urandom_range(0, 1);
        end
      endcase
      program_regs(cur_wr, cur_rd, cur_en);
      steady = ($urandom_range(0, 3) == 0);
      n_xfer = (cur_rd > 200) ? 1 : $urandom_range(2, 6);
      repeat (n_xfer) begin
        repeat ($urandom_range(0, 2))
          send_load($urandom_range(0, SEND_DEPTH_DEF - 1), 8'($urandom), ctl_t'($urandom_range(0, 3)));
        repeat ($urandom_range(0, 1)) send_noise();
        run_transfer();
      end
      phase++;
    end

    drain();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d requests in %0d transfers over %0d register settings, %0d results checked",
             requests_sent, transfers, settings, results_checked);
    $display("Covered table controls, all status codes, stray requests and output back-pressure");
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/i2cmts_pkg.sv
rtl/i2cmts_send_table.sv
rtl/i2c_master_transaction_sequencer.sv
rtl/i2cmts_checker.sv
tb/i2cmts_sequencer_checker.sv
tb/tb_i2c_master_transaction_sequencer.sv
